### rtl/rasf_pkg.sv
// Shared types and constants of the robot action safety filter.
// No dependencies; imported by rasf_mul, rasf_iter, the top level and the testbench.
package rasf_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TRANS_ALPHA = 3'd0,
		REG_ROT_ALPHA   = 3'd1,
		REG_TRANS_DB    = 3'd2,
		REG_ROT_DB      = 3'd3,
		REG_TRANS_LIM   = 3'd4,
		REG_ROT_LIM     = 3'd5,
		REG_GRIP_DB     = 3'd6,
		REG_IGNORE_GRIP = 3'd7
	} rasf_reg_t;

	// operation of the shared iterative unit
	typedef enum logic {
		ITER_SQRT = 1'b0,
		ITER_DIV  = 1'b1
	} rasf_iter_op_t;

	typedef struct packed {
		logic          start;
		rasf_iter_op_t op;
	} rasf_iter_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rasf_iter_stat_t;

	localparam int unsigned ALPHA_W   = 17;
	localparam int unsigned CFG_W     = 31;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned LEN_W     = 3;
	localparam int unsigned OPND_W    = 33;
	localparam int unsigned PROD_W    = 66;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
	localparam logic [PROD_W-1:0]  ROUND_HALF = 66'd32768;

endpackage

### rtl/rasf_mul.sv
// Shared signed 33x33 multiplier with registered product.
// Depends on rasf_pkg.
module rasf_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [rasf_pkg::OPND_W-1:0]  op_a,
	input  logic signed [rasf_pkg::OPND_W-1:0]  op_b,
	output logic signed [rasf_pkg::PROD_W-1:0]  prod_q
);
	import rasf_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule

### rtl/rasf_iter.sv
// Shared bit-serial unit: 64-bit integer square root (32 steps) or
// 64-by-32 restoring division (64 steps), one subtract per cycle. Depends on rasf_pkg.
module rasf_iter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rasf_pkg::rasf_iter_req_t    req,
	input  logic [63:0]                 x,
	input  logic [31:0]                 d,
	output rasf_pkg::rasf_iter_stat_t   stat,
	output logic [31:0]                 result
);
	import rasf_pkg::*;

	logic          busy_q, done_q;
	rasf_iter_op_t op_q;
	logic [5:0]    cnt_q;
	logic [63:0]   rem_q, acc_q, bit_q;
	logic [31:0]   d_q;
	logic [63:0]   shifted, minu, subt;
	logic [64:0]   diff;
	logic          ge, last;

	always_comb begin
		shifted = {rem_q[62:0], acc_q[63]};
		minu    = (op_q == ITER_SQRT) ? rem_q : shifted;
		subt    = (op_q == ITER_SQRT) ? (acc_q | bit_q) : {32'd0, d_q};
		diff    = {1'b0, minu} - {1'b0, subt};
		ge      = ~diff[64];
		last    = (op_q == ITER_SQRT) ? (cnt_q == 6'd31) : (cnt_q == 6'd63);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ITER_SQRT;
			cnt_q  <= '0;
			rem_q  <= '0;
			acc_q  <= '0;
			bit_q  <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= '0;
				d_q    <= d;
				bit_q  <= 64'd1 << 62;
				if (req.op == ITER_SQRT) begin
					rem_q <= x;
					acc_q <= '0;
				end else begin
					rem_q <= '0;
					acc_q <= x;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (op_q == ITER_SQRT) begin
					if (ge) begin
						rem_q <= diff[63:0];
						acc_q <= (acc_q >> 1) | bit_q;
					end else begin
						acc_q <= acc_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					rem_q <= ge ? diff[63:0] : shifted;
					acc_q <= {acc_q[62:0], ge};
				end
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = acc_q[31:0];

endmodule

### rtl/robot_action_safety_filter.sv
// Top level of the robot action safety filter: sequencer, vector registers,
// configuration registers. Depends on rasf_pkg, rasf_mul and rasf_iter.
//
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// input    | in_valid / in_ready   | trans_x..rot_z, grip, vec_length
// output   | out_valid / out_ready | out_trans_x..out_rot_z, out_grip, out_length
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// One transaction at a time: in_ready is high only while the sequencer idles.
// Short vectors pass quickest; an item is slowest with both groups smoothed
// and clipped and the gripper smoothed, where the 64-step divider, run
// once per clipped element, and the 32-step square root dominate.
// Reset clears the previous vector, so the first item is never smoothed.
// The result waits in the output register while the next item is taken;
// a stalled output only blocks the final write-back state.
module robot_action_safety_filter #(
	parameter int GRIPPER_ALPHA = 65536,
	parameter int SAMPLE_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] trans_x,
	input  logic [31:0] trans_y,
	input  logic [31:0] trans_z,
	input  logic [31:0] rot_x,
	input  logic [31:0] rot_y,
	input  logic [31:0] rot_z,
	input  logic [31:0] grip,
	input  logic [2:0]  vec_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_trans_x,
	output logic [31:0] out_trans_y,
	output logic [31:0] out_trans_z,
	output logic [31:0] out_rot_x,
	output logic [31:0] out_rot_y,
	output logic [31:0] out_rot_z,
	output logic [31:0] out_grip,
	output logic [2:0]  out_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rasf_pkg::*;

	localparam int EFF_W = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
	localparam logic [ALPHA_W-1:0] GRIP_ALPHA = ALPHA_W'(GRIPPER_ALPHA);
	localparam logic GRIP_SMOOTH = (GRIPPER_ALPHA < 65536);

	typedef enum logic [19:0] {
		S_IDLE      = 20'h00001,
		S_GRP       = 20'h00002,
		S_EMA_A     = 20'h00004,
		S_EMA_B     = 20'h00008,
		S_EMA_C     = 20'h00010,
		S_EMA_D     = 20'h00020,
		S_SQ        = 20'h00040,
		S_SQ_ACC    = 20'h00080,
		S_DB        = 20'h00100,
		S_DB_CMP    = 20'h00200,
		S_LIM       = 20'h00400,
		S_LIM_CMP   = 20'h00800,
		S_SQRT      = 20'h01000,
		S_CLIP_MUL  = 20'h02000,
		S_CLIP_DIV  = 20'h04000,
		S_CLIP_WAIT = 20'h08000,
		S_NEXT      = 20'h10000,
		S_GRIP      = 20'h20000,
		S_GHOLD     = 20'h40000,
		S_DONE      = 20'h80000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [ALPHA_W-1:0] trans_alpha_q, rot_alpha_q;
	logic [CFG_W-1:0]   trans_db_q, rot_db_q, trans_lim_q, rot_lim_q, grip_db_q;
	logic               ignore_grip_q;

	// working vector and previous filtered vector
	logic signed [31:0] v_q [7];
	logic signed [31:0] prev_q [7];
	logic               prev_valid_q;
	logic [2:0]         prev_len_q;
	logic [2:0]         len_q;
	logic               has_prev_q;
	logic               grp_q;
	logic [1:0]         idx_q;
	logic               grip_ph_q;
	logic [31:0]        norm_q;
	logic signed [PROD_W-1:0] acc_q;
	logic               out_valid_q;
	logic [31:0]        out_q [7];
	logic [2:0]         out_len_q;

	// datapath wires
	logic [31:0]        in_arr [6];
	logic               in_has_grip;
	logic [2:0]         in_plain;
	logic [2:0]         slot;
	logic [2:0]         base;
	logic signed [31:0] v_cur, prev_cur;
	logic [31:0]        v_mag;
	logic [ALPHA_W-1:0] alpha_g, alpha_eff;
	logic [CFG_W-1:0]   db_g, lim_g;
	logic               grp_en, has_grip;
	logic               mul_en;
	logic signed [OPND_W-1:0] op_a, op_b;
	logic signed [PROD_W-1:0] prod_q;
	rasf_iter_req_t     iter_req;
	rasf_iter_stat_t    iter_stat;
	logic [31:0]        iter_res;
	logic signed [32:0] gdiff;
	logic [32:0]        gmag;

	function automatic logic signed [31:0] sext_sample(input logic [31:0] raw);
		return 32'(signed'(raw[EFF_W-1:0]));
	endfunction

	always_comb begin
		in_arr[0]   = trans_x;
		in_arr[1]   = trans_y;
		in_arr[2]   = trans_z;
		in_arr[3]   = rot_x;
		in_arr[4]   = rot_y;
		in_arr[5]   = rot_z;
		in_has_grip = (vec_length == 3'd4) || (vec_length == 3'd7);
		in_plain    = in_has_grip ? vec_length - 3'd1 : vec_length;

		base      = grp_q ? 3'd3 : 3'd0;
		slot      = grip_ph_q ? 3'd6 : base + {1'b0, idx_q};
		v_cur     = v_q[slot];
		prev_cur  = prev_q[slot];
		v_mag     = v_cur[31] ? 32'(-v_cur) : 32'(v_cur);
		alpha_g   = grp_q ? rot_alpha_q : trans_alpha_q;
		db_g      = grp_q ? rot_db_q : trans_db_q;
		lim_g     = grp_q ? rot_lim_q : trans_lim_q;
		alpha_eff = grip_ph_q ? GRIP_ALPHA : alpha_g;
		grp_en    = grp_q ? (len_q >= 3'd6) : (len_q >= 3'd3);
		has_grip  = (len_q == 3'd4) || (len_q == 3'd7);

		gdiff = 33'(v_q[6]) - 33'(prev_q[6]);
		gmag  = gdiff[32] ? 33'(-gdiff) : 33'(gdiff);

		// at most one product per cycle from the shared multiplier, enabled only in the multiplying states
		mul_en = 1'b1;
		op_a   = '0;
		op_b   = '0;
		case (state_q)
			S_EMA_A: begin
				op_a = OPND_W'(v_cur);
				op_b = OPND_W'(alpha_eff);
			end
			S_EMA_B: begin
				op_a = OPND_W'(prev_cur);
				op_b = OPND_W'(ALPHA_ONE - alpha_eff);
			end
			S_SQ: begin
				op_a = {1'b0, v_mag};
				op_b = {1'b0, v_mag};
			end
			S_DB: begin
				op_a = {2'b00, db_g};
				op_b = {2'b00, db_g};
			end
			S_LIM: begin
				op_a = {2'b00, lim_g};
				op_b = {2'b00, lim_g};
			end
			S_CLIP_MUL: begin
				op_a = {1'b0, v_mag};
				op_b = {2'b00, lim_g};
			end
			default: mul_en = 1'b0;
		endcase

		// launch the square root once the limit is exceeded, the divide per element
		iter_req.start = 1'b0;
		iter_req.op    = ITER_SQRT;
		if (state_q == S_LIM_CMP && acc_q > prod_q) begin
			iter_req.start = 1'b1;
		end else if (state_q == S_CLIP_DIV) begin
			iter_req.start = 1'b1;
			iter_req.op    = ITER_DIV;
		end
	end

	rasf_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	rasf_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iter_req),
		.x      (state_q == S_CLIP_DIV ? prod_q[63:0] : acc_q[63:0]),
		.d      (norm_q),
		.stat   (iter_stat),
		.result (iter_res)
	);

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_alpha_q <= ALPHA_ONE;
			rot_alpha_q   <= ALPHA_ONE;
			trans_db_q    <= '0;
			rot_db_q      <= '0;
			trans_lim_q   <= '0;
			rot_lim_q     <= '0;
			grip_db_q     <= '0;
			ignore_grip_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TRANS_ALPHA: trans_alpha_q <= cfg_data[ALPHA_W-1:0];
				REG_ROT_ALPHA:   rot_alpha_q   <= cfg_data[ALPHA_W-1:0];
				REG_TRANS_DB:    trans_db_q    <= cfg_data[CFG_W-1:0];
				REG_ROT_DB:      rot_db_q      <= cfg_data[CFG_W-1:0];
				REG_TRANS_LIM:   trans_lim_q   <= cfg_data[CFG_W-1:0];
				REG_ROT_LIM:     rot_lim_q     <= cfg_data[CFG_W-1:0];
				REG_GRIP_DB:     grip_db_q     <= cfg_data[CFG_W-1:0];
				REG_IGNORE_GRIP: ignore_grip_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_valid_q <= 1'b0;
			prev_len_q   <= '0;
			len_q        <= '0;
			has_prev_q   <= 1'b0;
			grp_q        <= 1'b0;
			idx_q        <= '0;
			grip_ph_q    <= 1'b0;
			norm_q       <= '0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
			out_len_q    <= '0;
			for (int k = 0; k < 7; k++) begin
				v_q[k]    <= '0;
				prev_q[k] <= '0;
				out_q[k]  <= '0;
			end
		end else begin
			// drop the result once the consumer takes it; write-back reloads it
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						// place the elements; fields past the length read as zero
						for (int k = 0; k < 6; k++) begin
							v_q[k] <= (3'(k) < in_plain) ? sext_sample(in_arr[k]) : '0;
						end
						v_q[6]     <= in_has_grip ? sext_sample(grip) : '0;
						len_q      <= vec_length;
						has_prev_q <= prev_valid_q && (prev_len_q == vec_length);
						grp_q      <= 1'b0;
						grip_ph_q  <= 1'b0;
						state_q    <= S_GRP;
					end
				end
				S_GRP: begin
					idx_q     <= '0;
					grip_ph_q <= 1'b0;
					acc_q     <= '0;
					if (!grp_en) begin
						state_q <= S_NEXT;
					end else if (has_prev_q && !alpha_g[ALPHA_W-1]) begin
						state_q <= S_EMA_A;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_EMA_A: state_q <= S_EMA_B;
				S_EMA_B: begin
					acc_q   <= prod_q;
					state_q <= S_EMA_C;
				end
				S_EMA_C: begin
					acc_q   <= acc_q + prod_q + ROUND_HALF;
					state_q <= S_EMA_D;
				end
				S_EMA_D: begin
					// floor of the rounded weighted sum, Q16.16
					v_q[slot] <= acc_q[47:16];
					if (grip_ph_q) begin
						state_q <= S_GHOLD;
					end else if (idx_q == 2'd2) begin
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_SQ;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_EMA_A;
					end
				end
				S_SQ: state_q <= S_SQ_ACC;
				S_SQ_ACC: begin
					acc_q <= acc_q + prod_q;
					if (idx_q == 2'd2) begin
						idx_q   <= '0;
						state_q <= S_DB;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_SQ;
					end
				end
				S_DB: state_q <= S_DB_CMP;
				S_DB_CMP: begin
					if (acc_q < prod_q) begin
						// below the deadband: zero the whole group
						for (int k = 0; k < 3; k++) begin
							v_q[base + 3'(k)] <= '0;
						end
						state_q <= S_NEXT;
					end else if (lim_g == '0) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_LIM;
					end
				end
				S_LIM: state_q <= S_LIM_CMP;
				S_LIM_CMP: begin
					state_q <= (acc_q > prod_q) ? S_SQRT : S_NEXT;
				end
				S_SQRT: begin
					if (iter_stat.done) begin
						norm_q  <= iter_res;
						idx_q   <= '0;
						state_q <= S_CLIP_MUL;
					end
				end
				S_CLIP_MUL: state_q <= S_CLIP_DIV;
				S_CLIP_DIV: state_q <= S_CLIP_WAIT;
				S_CLIP_WAIT: begin
					if (iter_stat.done) begin
						v_q[slot] <= v_cur[31] ? 32'(-iter_res) : iter_res;
						if (idx_q == 2'd2) begin
							state_q <= S_NEXT;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_CLIP_MUL;
						end
					end
				end
				S_NEXT: begin
					if (!grp_q) begin
						grp_q   <= 1'b1;
						state_q <= S_GRP;
					end else begin
						state_q <= S_GRIP;
					end
				end
				S_GRIP: begin
					if (has_grip && ignore_grip_q) begin
						v_q[6]  <= '0;
						state_q <= S_DONE;
					end else if (has_grip && has_prev_q) begin
						grip_ph_q <= 1'b1;
						state_q   <= GRIP_SMOOTH ? S_EMA_A : S_GHOLD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_GHOLD: begin
					// hold the previous gripper value on small changes
					if (gmag < {2'b00, grip_db_q}) begin
						v_q[6] <= prev_q[6];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						for (int k = 0; k < 7; k++) begin
							out_q[k]  <= v_q[k];
							prev_q[k] <= v_q[k];
						end
						out_len_q    <= len_q;
						out_valid_q  <= 1'b1;
						prev_valid_q <= 1'b1;
						prev_len_q   <= len_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign out_trans_x = out_q[0];
	assign out_trans_y = out_q[1];
	assign out_trans_z = out_q[2];
	assign out_rot_x   = out_q[3];
	assign out_rot_y   = out_q[4];
	assign out_rot_z   = out_q[5];
	assign out_grip    = out_q[6];
	assign out_length  = out_len_q;

endmodule

### rtl/rasf_checker.sv
// Port-level checks of the robot action safety filter, bound to the top level.
// Depends on robot_action_safety_filter.
module rasf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_trans_x,
	input logic [31:0] out_rot_z,
	input logic [31:0] out_grip,
	input logic [2:0]  out_length
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_grip) && $stable(out_length))
		else $error("result changed while stalled");

	// busy after taking a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a transaction");

	// empty vector gives zeros in out_trans_x and out_rot_z
	a_len0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_length == 3'd0 |-> out_trans_x == 32'd0 && out_rot_z == 32'd0)
		else $error("nonzero field in empty vector");

	// no gripper for lengths 3 and 6
	a_nogrip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_length == 3'd3 || out_length == 3'd6) |-> out_grip == 32'd0)
		else $error("gripper set without gripper element");

endmodule

bind robot_action_safety_filter rasf_checker u_rasf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_trans_x (out_trans_x),
	.out_rot_z   (out_rot_z),
	.out_grip    (out_grip),
	.out_length  (out_length)
);

### tb/sv/tb_robot_action_safety_filter.sv
// Testbench of robot_action_safety_filter: directed and random action vectors
// checked against a cycle-free predictor of the filter. Depends on rasf_pkg and the RTL.
module tb_robot_action_safety_filter;
	import rasf_pkg::*;

	localparam int GRIP_ALPHA = 65536;

	typedef struct {
		logic [31:0] f [7];
		logic [2:0]  len;
	} action_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] trans_x = '0, trans_y = '0, trans_z = '0;
	logic [31:0] rot_x = '0, rot_y = '0, rot_z = '0, grip = '0;
	logic [2:0]  vec_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] out_trans_x, out_trans_y, out_trans_z;
	logic [31:0] out_rot_x, out_rot_y, out_rot_z, out_grip;
	logic [2:0]  out_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	robot_action_safety_filter dut (.*);

	always #10 clk = ~clk;

	// predictor copy of the configuration registers
	longint unsigned p_alpha [2];
	longint unsigned p_db [2];
	longint unsigned p_lim [2];
	longint unsigned p_grip_db;
	bit              p_ignore_grip;
	// predictor copy of the previous filtered vector
	longint          prev_vec [7];
	bit              prev_ok;
	bit [2:0]        prev_len;
	longint          work [7];

	action_t filtered_q [$];
	int      errors = 0;
	bit      quiet = 1'b0;   // set to suppress all idling on both sides

	// result field names for mismatch reports
	string   nm [7] = '{"out_trans_x", "out_trans_y", "out_trans_z",
		"out_rot_x", "out_rot_y", "out_rot_z", "out_grip"};

	// Smoothing step: cur*a + prev*(1-a), rounded half up, floored in Q16.16; a of one or more returns cur.
	function automatic longint smooth(longint cur, longint prv, longint unsigned a);
		if (a >= 65536)
			return cur;
		return (cur * longint'(a) + prv * (65536 - longint'(a)) + 32768) >>> 16;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned res = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned absval(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// Smooth, deadband and clip one three-element group of work[] at base b.
	task automatic shape_group(int b, bit hp, longint unsigned a,
			longint unsigned db, longint unsigned lim);
		longint unsigned sum = 0;
		longint unsigned nrm;
		longint unsigned q;
		if (hp)
			for (int i = 0; i < 3; i++)
				work[b+i] = smooth(work[b+i], prev_vec[b+i], a);
		for (int i = 0; i < 3; i++)
			sum += absval(work[b+i]) * absval(work[b+i]);
		if (sum < db * db) begin
			for (int i = 0; i < 3; i++)
				work[b+i] = 0;
			return;
		end
		if (lim == 0 || sum <= lim * lim)
			return;
		nrm = isqrt(sum);
		if (nrm == 0)
			return;
		for (int i = 0; i < 3; i++) begin
			q = absval(work[b+i]) * lim / nrm;
			work[b+i] = work[b+i] < 0 ? -longint'(q) : longint'(q);
		end
	endtask

	// Work out the filtered vector of one accepted transaction and queue it.
	task automatic predict_filtered(logic [31:0] raw [7], logic [2:0] len);
		action_t         e;
		bit              has_grip = (len == 4 || len == 7);
		int              plain = has_grip ? len - 1 : len;
		bit              hp = prev_ok && prev_len == len;
		longint          g;
		for (int i = 0; i < 7; i++)
			work[i] = 0;
		for (int i = 0; i < 6; i++)
			if (i < plain)
				work[i] = longint'($signed(raw[i]));
		if (has_grip)
			work[6] = longint'($signed(raw[6]));
		if (len >= 3)
			shape_group(0, hp, p_alpha[0], p_db[0], p_lim[0]);
		if (len >= 6)
			shape_group(3, hp, p_alpha[1], p_db[1], p_lim[1]);
		if (has_grip) begin
			if (p_ignore_grip) begin
				work[6] = 0;
			end else if (hp) begin
				g = smooth(work[6], prev_vec[6], GRIP_ALPHA);
				if (absval(g - prev_vec[6]) < p_grip_db)
					g = prev_vec[6];
				work[6] = g;
			end
		end
		for (int i = 0; i < 7; i++) begin
			prev_vec[i] = work[i];
			e.f[i] = work[i][31:0];
		end
		prev_ok = 1'b1;
		prev_len = len;
		e.len = len;
		filtered_q.push_back(e);
	endtask

	function automatic int gap_len();
		int r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Send one vector; called at a rising edge, returns at a rising edge.
	task automatic send_vector(logic [31:0] raw [7], logic [2:0] len);
		int gap;
		trans_x <= raw[0]; trans_y <= raw[1]; trans_z <= raw[2];
		rot_x <= raw[3]; rot_y <= raw[4]; rot_z <= raw[5]; grip <= raw[6];
		vec_length <= len;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_filtered(raw, len);
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait for every result, let the block settle, then write one register.
	task automatic write_reg(rasf_reg_t idx, logic [31:0] data);
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TRANS_ALPHA: p_alpha[0] = data[16:0];
			REG_ROT_ALPHA:   p_alpha[1] = data[16:0];
			REG_TRANS_DB:    p_db[0] = data[30:0];
			REG_ROT_DB:      p_db[1] = data[30:0];
			REG_TRANS_LIM:   p_lim[0] = data[30:0];
			REG_ROT_LIM:     p_lim[1] = data[30:0];
			REG_GRIP_DB:     p_grip_db = data[30:0];
			REG_IGNORE_GRIP: p_ignore_grip = data[0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_sample();
		int r = $urandom_range(0, 9);
		case (r)
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
		endcase
	endfunction

	// Pad random upper bits above a register's width so they get exercised.
	function automatic logic [31:0] pad_cfg(logic [31:0] v, int w);
		logic [31:0] m = (w >= 32) ? '1 : ((32'd1 << w) - 1);
		return (v & m) | ($urandom & ~m);
	endfunction

	task automatic send_uniform(logic [31:0] v, logic [2:0] len);
		logic [31:0] raw [7];
		for (int i = 0; i < 7; i++)
			raw[i] = v;
		send_vector(raw, len);
	endtask

	// Every length at the sample extremes, with reset config.
	task automatic test_lengths();
		for (int l = 0; l < 8; l++) begin
			send_uniform(32'h7FFF_FFFF, l[2:0]);
			send_uniform(32'h8000_0000, l[2:0]);
		end
	endtask

	// Smoothing, deadbands, clipping and gripper handling, directed.
	task automatic test_filter_paths();
		write_reg(REG_TRANS_ALPHA, 32'h0000_4000);
		write_reg(REG_ROT_ALPHA, 32'h0001_FFFF);   // above one: no smoothing
		write_reg(REG_TRANS_LIM, 32'h0003_0000);
		write_reg(REG_ROT_LIM, 32'h7FFF_FFFF);
		write_reg(REG_GRIP_DB, 32'h0002_0000);
		send_uniform(32'h0010_0000, 3'd7);
		send_uniform(32'hFFF0_0000, 3'd7);   // same length: smoothed
		send_uniform(32'h0001_0000, 3'd7);   // grip change above the deadband: not held
		send_uniform(32'h0001_0000, 3'd5);   // length change: no smoothing
		write_reg(REG_TRANS_DB, 32'h7FFF_FFFF);
		write_reg(REG_ROT_DB, 32'h0000_8000);
		write_reg(REG_IGNORE_GRIP, 32'h0000_0001);
		send_uniform(32'h0000_4000, 3'd6);
		send_uniform(32'h0000_4000, 3'd4);
		write_reg(REG_TRANS_ALPHA, 32'h0000_0000);
		send_uniform(32'h7FFF_FFFF, 3'd4);
	endtask

	task automatic random_config();
		int r;
		for (int k = 0; k < 2; k++) begin
			r = $urandom_range(0, 3);
			write_reg(rasf_reg_t'(k), pad_cfg(r == 0 ? 32'd0 : r == 1 ? 32'd65536 :
				r == 2 ? 32'h1_FFFF : $urandom_range(0, 65536), ALPHA_W));
		end
		for (int k = 2; k < 7; k++) begin
			r = $urandom_range(0, 5);
			write_reg(rasf_reg_t'(k), pad_cfg(r == 0 ? 32'd0 : r == 1 ? 32'h7FFF_FFFF :
				$urandom_range(0, 32'h6_0000), CFG_W));
		end
		write_reg(REG_IGNORE_GRIP, pad_cfg($urandom_range(0, 3) == 0, 1));
	endtask

	// Random phases: mostly runs of one length so smoothing and hold engage.
	task automatic test_random_streams();
		logic [31:0] raw [7];
		logic [2:0]  len;
		int          sent = 0;
		while (sent < 500) begin
			random_config();
			quiet = ($urandom_range(0, 4) == 0);
			len = $urandom_range(0, 7);
			repeat (25) begin
				if ($urandom_range(0, 5) == 0)
					len = $urandom_range(0, 7);
				for (int i = 0; i < 7; i++)
					raw[i] = rand_sample();
				send_vector(raw, len);
				sent++;
			end
		end
		quiet = 1'b0;
	endtask

	// Receiver: random stalls on out_ready.
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left <= gap_len();
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		action_t     e;
		logic [31:0] got [7];
		if (arst_n && out_valid && out_ready) begin
			got = '{out_trans_x, out_trans_y, out_trans_z, out_rot_x, out_rot_y,
				out_rot_z, out_grip};
			if (filtered_q.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = filtered_q.pop_front();
				for (int i = 0; i < 7; i++)
					if (got[i] !== e.f[i]) begin
						$error("%s expected %h actual %h", nm[i], e.f[i], got[i]);
						errors++;
					end
				if (out_length !== e.len) begin
					$error("out_length expected %0d actual %0d", e.len, out_length);
					errors++;
				end
			end
		end
	end

	initial begin
		p_alpha = '{65536, 65536};
		p_db = '{0, 0};
		p_lim = '{0, 0};
		p_grip_db = 0;
		p_ignore_grip = 0;
		prev_ok = 0;
		prev_len = 0;
		for (int i = 0; i < 7; i++)
			prev_vec[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lengths();
		test_filter_paths();
		test_random_streams();
		in_valid <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#60_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
